>>> sv/uart_command_console_parser_core_defines.svh
// assertion macros shared by the console parser rtl
`ifndef UART_COMMAND_CONSOLE_PARSER_CORE_DEFINES_SVH
`define UART_COMMAND_CONSOLE_PARSER_CORE_DEFINES_SVH

// same-cycle implication, disabled while reset is asserted
`define UCC_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define UCC_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> sv/ucc_pkg.sv
// types, constants and helper functions of the console parser
package ucc_pkg;

  // line store geometry
  localparam int unsigned LineDepth = 32;
  localparam int unsigned IdxW      = $clog2(LineDepth);
  typedef logic [IdxW-1:0] idx_t;
  localparam idx_t LastIdx = idx_t'(LineDepth - 1);

  // converter reading width and binary to bcd step count
  localparam int unsigned AdcW = 10;
  localparam int unsigned DdCntW = $clog2(AdcW + 1);
  typedef logic [DdCntW-1:0] dd_cnt_t;
  localparam dd_cnt_t DdSteps = dd_cnt_t'(AdcW);

  // character positions inside a command line
  localparam idx_t PosArg    = idx_t'(14);
  localparam idx_t PosArgEnd = idx_t'(20);
  localparam idx_t PosAdcEnd = idx_t'(18);
  localparam idx_t PosDig0   = idx_t'(20);
  localparam idx_t PosDig1   = idx_t'(21);
  localparam idx_t PosDig2   = idx_t'(22);
  localparam idx_t PosDig3   = idx_t'(23);
  localparam idx_t PosLast   = idx_t'(24);

  // special characters
  localparam logic [7:0] ChCr    = 8'h0D;
  localparam logic [7:0] ChBs    = 8'h08;
  localparam logic [7:0] ChNul   = 8'h00;
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChZero  = 8'h30;
  localparam logic [7:0] ChOne   = 8'h31;
  localparam logic [7:0] ChNine  = 8'h39;

  // command text
  localparam logic [8*14-1:0] KwSet  = {"/set", "_register "};
  localparam logic [8*14-1:0] KwGet  = {"/get", "_register "};
  localparam logic [8*14-1:0] KwSend = {"/send_via", "_SPI "};
  localparam logic [8*6-1:0]  ArgMux   = "ADMUX ";
  localparam logic [8*6-1:0]  ArgValue = "VALUE ";
  localparam logic [8*3-1:0]  ArgAdc   = "ADC";

  // result codes
  typedef enum logic [1:0] {
    StOk       = 2'd0,
    StUnknown  = 2'd1,
    StInvalid  = 2'd2,
    StOverflow = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    ActNone   = 2'd0,
    ActMux    = 2'd1,
    ActReport = 2'd2,
    ActFrame  = 2'd3
  } action_e;

  // character i of a 14 character keyword
  function automatic logic [7:0] kw_char(input logic [8*14-1:0] s, input logic [3:0] i);
    logic [8*14-1:0] sh;
    sh = s << {i, 3'b000};
    return sh[8*14-1 -: 8];
  endfunction

  // character i of a 6 character argument word
  function automatic logic [7:0] arg_char(input logic [8*6-1:0] s, input logic [2:0] i);
    logic [8*6-1:0] sh;
    sh = s << {i, 3'b000};
    return sh[8*6-1 -: 8];
  endfunction

  // character i of a 3 character argument word
  function automatic logic [7:0] arg3_char(input logic [8*3-1:0] s, input logic [1:0] i);
    logic [8*3-1:0] sh;
    sh = s << {i, 3'b000};
    return sh[8*3-1 -: 8];
  endfunction

  // seven-segment code of one decimal digit
  function automatic logic [7:0] seg_code(input logic [3:0] d);
    logic [7:0] s;
    case (d)
      4'd0:    s = 8'b00111111;
      4'd1:    s = 8'b00000110;
      4'd2:    s = 8'b01011011;
      4'd3:    s = 8'b01001111;
      4'd4:    s = 8'b01100110;
      4'd5:    s = 8'b01101101;
      4'd6:    s = 8'b01111101;
      4'd7:    s = 8'b00000111;
      4'd8:    s = 8'b01111111;
      4'd9:    s = 8'b01101111;
      default: s = 8'b00000000;
    endcase
    return s;
  endfunction

  // inverted segment frame, ones digit in the low byte
  function automatic logic [31:0] make_frame(input logic [15:0] bcd);
    return {~seg_code(bcd[15:12]), ~seg_code(bcd[11:8]),
            ~seg_code(bcd[7:4]), ~seg_code(bcd[3:0])};
  endfunction

endpackage

>>> sv/ucc_ram.sv
// generic simple dual-port ram with registered read
module ucc_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> sv/uart_command_console_parser_core.sv
// Console command parser: received characters in, command results out.
//
// Input channel: in_valid_i / in_stall_o with rx_byte_i and adc_value_i.
// Output channel: out_valid_o / out_stall_i with status_o, action_o,
// channel_o, reference_o and segment_frame_o. A transfer happens when valid
// is high and stall is low.
// Ordinary characters and backspaces give no result, so while the block
// is idle they stream one per cycle. A character that fills the last line
// entry loads an overflow result through the emit state once the output
// register is free, and holds the input until then. A carriage return
// starts a walk of the line store: one stored character is read and
// compared per cycle over positions 0 to 24, while the converter reading is
// turned to decimal digits one bit per cycle. The scan end, done and emit
// states follow; the result is loaded once the output register is free,
// then input is taken again. The walk is set by the store's single read port.
// The block keeps taking characters while a result waits in the output
// register; a new result waits until the previous one has been taken.
// Reset empties the line and clears channel and reference to zero.
`include "uart_command_console_parser_core_defines.svh"

module uart_command_console_parser_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  rx_byte_i,
  input  logic [9:0]  adc_value_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  status_o,
  output logic [1:0]  action_o,
  output logic        channel_o,
  output logic        reference_o,
  output logic [31:0] segment_frame_o
);

  typedef enum logic [2:0] {
    SIdle,
    SScan,
    SScanEnd,
    SDone,
    SEmit
  } state_e;

  // control registers
  state_e           state_q, state_d;
  ucc_pkg::idx_t    wi_q, wi_d;
  ucc_pkg::idx_t    scan_q, scan_d;
  logic             chk_vld_q, chk_vld_d;
  logic             chan_q, chan_d;
  logic             ref_q, ref_d;
  logic             out_valid_q, out_valid_d;
  ucc_pkg::dd_cnt_t dd_cnt_q, dd_cnt_d;

  // payload registers
  ucc_pkg::idx_t    chk_pos_q, chk_pos_d;
  logic             set_h_q, set_h_d, get_h_q, get_h_d, send_h_q, send_h_d;
  logic             set_a_q, set_a_d, get_a_q, get_a_d;
  logic             adc_a_q, adc_a_d, val_a_q, val_a_d;
  logic             new_chan_q, new_chan_d, new_ref_q, new_ref_d;
  logic [15:0]      val_bcd_q, val_bcd_d;
  logic [ucc_pkg::AdcW-1:0] dd_bin_q, dd_bin_d;
  logic [15:0]      dd_bcd_q, dd_bcd_d;
  ucc_pkg::status_e res_status_q, res_status_d;
  ucc_pkg::action_e res_action_q, res_action_d;
  logic [31:0]      res_frame_q, res_frame_d;
  ucc_pkg::status_e out_status_q, out_status_d;
  ucc_pkg::action_e out_action_q, out_action_d;
  logic             out_chan_q, out_chan_d;
  logic             out_ref_q, out_ref_d;
  logic [31:0]      out_frame_q, out_frame_d;

  // line store ports
  logic             ram_we;
  logic [7:0]       ram_rdata;

  logic             in_xfer;
  logic [7:0]       ch;
  logic             ch_dig;
  logic             ch_bit;
  ucc_pkg::idx_t    rel;
  logic [15:0]      dd_adj;

  assign in_stall_o = (state_q != SIdle);
  assign in_xfer    = in_valid_i && !in_stall_o;

  ucc_ram #(
    .Width (8),
    .Depth (ucc_pkg::LineDepth)
  ) u_line_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (wi_q),
    .wdata_i (rx_byte_i),
    .raddr_i (scan_q),
    .rdata_o (ram_rdata)
  );

  // character under compare; positions past the line read as nul
  assign ch     = (chk_pos_q < wi_q) ? ram_rdata : ucc_pkg::ChNul;
  assign ch_dig = (ch >= ucc_pkg::ChZero) && (ch <= ucc_pkg::ChNine);
  assign ch_bit = (ch == ucc_pkg::ChZero) || (ch == ucc_pkg::ChOne);
  assign rel    = chk_pos_q - ucc_pkg::PosArg;

  // add-3 correction of each bcd digit before the shift
  always_comb begin
    for (int n = 0; n < 4; n++) begin
      dd_adj[4*n +: 4] = (dd_bcd_q[4*n +: 4] >= 4'd5) ? dd_bcd_q[4*n +: 4] + 4'd3
                                                     : dd_bcd_q[4*n +: 4];
    end
  end

  // sequencer and datapath next state
  always_comb begin
    state_d      = state_q;
    wi_d         = wi_q;
    scan_d       = scan_q;
    chk_vld_d    = (state_q == SScan);
    chk_pos_d    = scan_q;
    chan_d       = chan_q;
    ref_d        = ref_q;
    out_valid_d  = out_valid_q;
    dd_cnt_d     = dd_cnt_q;
    set_h_d      = set_h_q;
    get_h_d      = get_h_q;
    send_h_d     = send_h_q;
    set_a_d      = set_a_q;
    get_a_d      = get_a_q;
    adc_a_d      = adc_a_q;
    val_a_d      = val_a_q;
    new_chan_d   = new_chan_q;
    new_ref_d    = new_ref_q;
    val_bcd_d    = val_bcd_q;
    dd_bin_d     = dd_bin_q;
    dd_bcd_d     = dd_bcd_q;
    res_status_d = res_status_q;
    res_action_d = res_action_q;
    res_frame_d  = res_frame_q;
    out_status_d = out_status_q;
    out_action_d = out_action_q;
    out_chan_d   = out_chan_q;
    out_ref_d    = out_ref_q;
    out_frame_d  = out_frame_q;
    ram_we       = 1'b0;

    // output register empties on a transfer
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    // compare one line character against every command
    if (chk_vld_q) begin
      if (chk_pos_q < ucc_pkg::PosArg) begin
        set_h_d  = set_h_q && (ch == ucc_pkg::kw_char(ucc_pkg::KwSet, chk_pos_q[3:0]));
        get_h_d  = get_h_q && (ch == ucc_pkg::kw_char(ucc_pkg::KwGet, chk_pos_q[3:0]));
        send_h_d = send_h_q && (ch == ucc_pkg::kw_char(ucc_pkg::KwSend, chk_pos_q[3:0]));
      end else if (chk_pos_q < ucc_pkg::PosArgEnd) begin
        set_a_d = set_a_q && (ch == ucc_pkg::arg_char(ucc_pkg::ArgMux, rel[2:0]));
        val_a_d = val_a_q && (ch == ucc_pkg::arg_char(ucc_pkg::ArgValue, rel[2:0]));
        if (rel[2:0] < 3'd5) begin
          get_a_d = get_a_q && (ch == ucc_pkg::arg_char(ucc_pkg::ArgMux, rel[2:0]));
        end else begin
          get_a_d = get_a_q && (ch == ucc_pkg::ChNul);
        end
        if (chk_pos_q < ucc_pkg::PosAdcEnd) begin
          if (rel[1:0] < 2'd3) begin
            adc_a_d = adc_a_q && (ch == ucc_pkg::arg3_char(ucc_pkg::ArgAdc, rel[1:0]));
          end else begin
            adc_a_d = adc_a_q && (ch == ucc_pkg::ChNul);
          end
        end
      end else if (chk_pos_q == ucc_pkg::PosDig0) begin
        set_a_d         = set_a_q && ch_bit;
        new_chan_d      = ch[0];
        val_a_d         = val_a_q && ch_dig;
        val_bcd_d[15:12] = ch[3:0];
      end else if (chk_pos_q == ucc_pkg::PosDig1) begin
        set_a_d        = set_a_q && (ch == ucc_pkg::ChSpace);
        val_a_d        = val_a_q && ch_dig;
        val_bcd_d[11:8] = ch[3:0];
      end else if (chk_pos_q == ucc_pkg::PosDig2) begin
        set_a_d        = set_a_q && ch_bit;
        new_ref_d      = ch[0];
        val_a_d        = val_a_q && ch_dig;
        val_bcd_d[7:4] = ch[3:0];
      end else if (chk_pos_q == ucc_pkg::PosDig3) begin
        set_a_d        = set_a_q && (ch == ucc_pkg::ChNul);
        val_a_d        = val_a_q && ch_dig;
        val_bcd_d[3:0] = ch[3:0];
      end else begin
        val_a_d = val_a_q && (ch == ucc_pkg::ChNul);
      end
    end

    // one binary to bcd step per scan cycle until all steps are done
    if ((state_q == SScan) && (dd_cnt_q != ucc_pkg::DdSteps)) begin
      dd_bcd_d = {dd_adj[14:0], dd_bin_q[ucc_pkg::AdcW-1]};
      dd_bin_d = {dd_bin_q[ucc_pkg::AdcW-2:0], 1'b0};
      dd_cnt_d = dd_cnt_q + ucc_pkg::dd_cnt_t'(1);
    end

    case (state_q)
      SIdle: begin
        if (in_xfer) begin
          if (rx_byte_i == ucc_pkg::ChBs) begin
            if (wi_q != '0) begin
              wi_d = wi_q - ucc_pkg::idx_t'(1);
            end
          end else if (rx_byte_i == ucc_pkg::ChCr) begin
            scan_d   = '0;
            set_h_d  = 1'b1;
            get_h_d  = 1'b1;
            send_h_d = 1'b1;
            set_a_d  = 1'b1;
            get_a_d  = 1'b1;
            adc_a_d  = 1'b1;
            val_a_d  = 1'b1;
            dd_bin_d = adc_value_i;
            dd_bcd_d = '0;
            dd_cnt_d = '0;
            state_d  = SScan;
          end else begin
            ram_we = 1'b1;
            if (wi_q == ucc_pkg::LastIdx) begin
              wi_d         = '0;
              res_status_d = ucc_pkg::StOverflow;
              res_action_d = ucc_pkg::ActNone;
              res_frame_d  = '0;
              state_d      = SEmit;
            end else begin
              wi_d = wi_q + ucc_pkg::idx_t'(1);
            end
          end
        end
      end
      SScan: begin
        scan_d = scan_q + ucc_pkg::idx_t'(1);
        if (scan_q == ucc_pkg::PosLast) begin
          state_d = SScanEnd;
        end
      end
      SScanEnd: begin
        state_d = SDone;
      end
      SDone: begin
        res_action_d = ucc_pkg::ActNone;
        res_frame_d  = '0;
        res_status_d = ucc_pkg::StInvalid;
        if (set_h_q) begin
          if (set_a_q) begin
            chan_d       = new_chan_q;
            ref_d        = new_ref_q;
            res_status_d = ucc_pkg::StOk;
            res_action_d = ucc_pkg::ActMux;
          end
        end else if (get_h_q) begin
          if (get_a_q) begin
            res_status_d = ucc_pkg::StOk;
            res_action_d = ucc_pkg::ActReport;
          end
        end else if (send_h_q) begin
          if (adc_a_q) begin
            res_frame_d  = ucc_pkg::make_frame(dd_bcd_q);
            res_status_d = ucc_pkg::StOk;
            res_action_d = ucc_pkg::ActFrame;
          end else if (val_a_q) begin
            res_frame_d  = ucc_pkg::make_frame(val_bcd_q);
            res_status_d = ucc_pkg::StOk;
            res_action_d = ucc_pkg::ActFrame;
          end
        end else begin
          res_status_d = ucc_pkg::StUnknown;
        end
        wi_d    = '0;
        state_d = SEmit;
      end
      SEmit: begin
        if (!out_valid_q || !out_stall_i) begin
          out_status_d = res_status_q;
          out_action_d = res_action_q;
          out_chan_d   = chan_q;
          out_ref_d    = ref_q;
          out_frame_d  = res_frame_q;
          out_valid_d  = 1'b1;
          state_d      = SIdle;
        end
      end
      default: begin
        state_d = SIdle;
      end
    endcase
  end

  // control state and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= SIdle;
      wi_q         <= '0;
      scan_q       <= '0;
      chk_vld_q    <= 1'b0;
      chan_q       <= 1'b0;
      ref_q        <= 1'b0;
      out_valid_q  <= 1'b0;
      dd_cnt_q     <= '0;
      out_status_q <= ucc_pkg::StOk;
      out_action_q <= ucc_pkg::ActNone;
      out_chan_q   <= 1'b0;
      out_ref_q    <= 1'b0;
      out_frame_q  <= '0;
    end else begin
      state_q      <= state_d;
      wi_q         <= wi_d;
      scan_q       <= scan_d;
      chk_vld_q    <= chk_vld_d;
      chan_q       <= chan_d;
      ref_q        <= ref_d;
      out_valid_q  <= out_valid_d;
      dd_cnt_q     <= dd_cnt_d;
      out_status_q <= out_status_d;
      out_action_q <= out_action_d;
      out_chan_q   <= out_chan_d;
      out_ref_q    <= out_ref_d;
      out_frame_q  <= out_frame_d;
    end
  end

  // compare flags, digits and result payload
  always_ff @(posedge clk_i) begin
    chk_pos_q    <= chk_pos_d;
    set_h_q      <= set_h_d;
    get_h_q      <= get_h_d;
    send_h_q     <= send_h_d;
    set_a_q      <= set_a_d;
    get_a_q      <= get_a_d;
    adc_a_q      <= adc_a_d;
    val_a_q      <= val_a_d;
    new_chan_q   <= new_chan_d;
    new_ref_q    <= new_ref_d;
    val_bcd_q    <= val_bcd_d;
    dd_bin_q     <= dd_bin_d;
    dd_bcd_q     <= dd_bcd_d;
    res_status_q <= res_status_d;
    res_action_q <= res_action_d;
    res_frame_q  <= res_frame_d;
  end

  assign out_valid_o     = out_valid_q;
  assign status_o        = out_status_q;
  assign action_o        = out_action_q;
  assign channel_o       = out_chan_q;
  assign reference_o     = out_ref_q;
  assign segment_frame_o = out_frame_q;

  // checks on the sequencer and the result coding
  `UCC_ASSERT_NEXT(a_line_cleared, clk_i, rst_ni, state_q == SDone, wi_q == '0,
    "line not emptied after a line end")
  `UCC_ASSERT_NEXT(a_cr_starts_scan, clk_i, rst_ni, in_xfer && (rx_byte_i == ucc_pkg::ChCr),
    state_q == SScan, "line end did not start the scan")
  `UCC_ASSERT_NOW(a_frame_only_sent, clk_i, rst_ni,
    out_valid_o && (action_o != ucc_pkg::ActFrame), segment_frame_o == '0,
    "frame nonzero without a frame action")
  `UCC_ASSERT_NOW(a_fail_no_action, clk_i, rst_ni,
    out_valid_o && (status_o != ucc_pkg::StOk), action_o == ucc_pkg::ActNone,
    "failed result carries an action")
  `UCC_ASSERT_NEXT(a_digits_ready, clk_i, rst_ni, state_q == SScanEnd,
    dd_cnt_q == ucc_pkg::DdSteps, "decimal conversion not finished at result time")

endmodule
